[rtl/tsc_pkg.sv]
// Shared constants, tables and types for the sine/cosine series pipeline.
package tsc_pkg;

	localparam int TERMS     = 14;
	localparam int FRAC_BITS = 16;
	localparam int IFB       = 24;
	localparam int SH        = IFB - FRAC_BITS;

	localparam int ANG_W = 24;
	localparam int VAL_W = 19;
	localparam int M_W   = ANG_W + SH;

	localparam logic [63:0] PERIOD_Q = 64'd105411248;
	localparam logic [63:0] ONE_Q    = 64'd1 << IFB;
	localparam logic [63:0] ACC_LIM  = 64'd512 << IFB;
	localparam logic [63:0] RND      = (SH > 0) ? (64'd1 << (SH - 1)) : 64'd0;

	localparam int RED_STEPS = $clog2((64'd1 << (M_W - 1)) / PERIOD_Q + 64'd1);

	localparam int XM_W   = 27;
	localparam int SQ_W   = 2 * XM_W;
	localparam int X2_W   = 30;
	localparam int ACC_W  = 34;
	localparam int ACC_LO = 17;
	localparam int PL_W   = X2_W + ACC_LO;
	localparam int PH_W   = X2_W + ACC_W - ACC_LO;
	localparam int D_W    = 11;
	localparam int N_W    = 40;
	localparam int RSH    = N_W + D_W;
	localparam int R_W    = RSH;
	localparam int NL_W   = 20;
	localparam int RL_W   = 26;
	localparam int RM_W   = 37;

	localparam int NSTEP = TERMS - 1;

	localparam logic [63:0] OUT_MAX     = 64'd262143;
	localparam logic [63:0] OUT_MIN_MAG = 64'd262144;

	// (2k)(2k+1) for sine, (2k-1)(2k) for cosine
	localparam logic [D_W-1:0] D_SIN [1:19] = '{
		11'd6,   11'd20,  11'd42,  11'd72,  11'd110, 11'd156, 11'd210,
		11'd272, 11'd342, 11'd420, 11'd506, 11'd600, 11'd702, 11'd812,
		11'd930, 11'd1056, 11'd1190, 11'd1332, 11'd1482
	};
	localparam logic [D_W-1:0] D_COS [1:19] = '{
		11'd2,   11'd12,  11'd30,  11'd56,  11'd90,  11'd132, 11'd182,
		11'd240, 11'd306, 11'd380, 11'd462, 11'd552, 11'd650, 11'd756,
		11'd870, 11'd992, 11'd1122, 11'd1260, 11'd1406
	};

	typedef struct packed {
		logic            func;
		logic            xneg;
		logic [XM_W-1:0] xm;
		logic [X2_W-1:0] x2;
	} tsc_side_t;

	typedef struct packed {
		logic             neg;
		logic [ACC_W-1:0] mag;
	} tsc_acc_t;

endpackage

[rtl/tsc_reduce.sv]
// Angle magnitude, range reduction by the truncated period and squaring.
module tsc_reduce (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_v,
	input  logic signed [tsc_pkg::ANG_W-1:0] angle,
	input  logic                            func,
	output logic                            out_v,
	output tsc_pkg::tsc_side_t              out_side
);

	localparam int RS = tsc_pkg::RED_STEPS;

	logic                      neg_in;
	logic [tsc_pkg::ANG_W-1:0] mag_in;
	logic [tsc_pkg::M_W-1:0]   m_in;
	logic                      eq_in;

	logic                    v_s1, neg_s1, func_s1, eq_s1;
	logic [tsc_pkg::M_W-1:0] m_s1;

	logic                    rv    [0:RS];
	logic                    rneg  [0:RS];
	logic                    rfunc [0:RS];
	logic                    req   [0:RS];
	logic [tsc_pkg::M_W-1:0] rm    [0:RS];

	logic [tsc_pkg::XM_W-1:0] xm_red;

	logic                     v_sp, neg_sp, func_sp;
	logic [tsc_pkg::XM_W-1:0] xm_sp;
	logic [tsc_pkg::SQ_W-1:0] sq_sp;

	logic               v_sx;
	tsc_pkg::tsc_side_t side_sx;

	assign neg_in = angle[tsc_pkg::ANG_W-1];
	assign mag_in = neg_in ? ($unsigned(~angle) + 1'b1) : $unsigned(angle);
	assign m_in   = tsc_pkg::M_W'(mag_in) << tsc_pkg::SH;
	assign eq_in  = (64'(m_in) == tsc_pkg::PERIOD_Q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1  <= neg_in;
			func_s1 <= func;
			eq_s1   <= eq_in;
			m_s1    <= m_in;
		end
	end

	assign rv[0]    = v_s1;
	assign rneg[0]  = neg_s1;
	assign rfunc[0] = func_s1;
	assign req[0]   = eq_s1;
	assign rm[0]    = m_s1;

	// restoring remainder, one multiple of the period per stage
	for (genvar i = 0; i < RS; i++) begin : g_red
		localparam logic [63:0] SUBV = tsc_pkg::PERIOD_Q << (RS - 1 - i);

		logic                    v_sr, neg_sr, func_sr, eq_sr;
		logic [tsc_pkg::M_W-1:0] m_sr;
		logic [63:0]             cur;
		logic                    ge;

		assign cur = 64'(rm[i]);
		assign ge  = (cur >= SUBV);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sr <= 1'b0;
			end else if (en) begin
				v_sr <= rv[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_sr  <= rneg[i];
				func_sr <= rfunc[i];
				eq_sr   <= req[i];
				m_sr    <= ge ? tsc_pkg::M_W'(cur - SUBV) : rm[i];
			end
		end

		assign rv[i+1]    = v_sr;
		assign rneg[i+1]  = neg_sr;
		assign rfunc[i+1] = func_sr;
		assign req[i+1]   = eq_sr;
		assign rm[i+1]    = m_sr;
	end

	// a magnitude exactly on the period is left alone
	assign xm_red = tsc_pkg::XM_W'(req[RS] ? tsc_pkg::PERIOD_Q : 64'(rm[RS]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sp <= 1'b0;
			v_sx <= 1'b0;
		end else if (en) begin
			v_sp <= rv[RS];
			v_sx <= v_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sp       <= rneg[RS];
			func_sp      <= rfunc[RS];
			xm_sp        <= xm_red;
			sq_sp        <= tsc_pkg::SQ_W'(xm_red) * tsc_pkg::SQ_W'(xm_red);
			side_sx.func <= func_sp;
			side_sx.xneg <= neg_sp;
			side_sx.xm   <= xm_sp;
			side_sx.x2   <= tsc_pkg::X2_W'((sq_sp + tsc_pkg::SQ_W'(tsc_pkg::ONE_Q >> 1))
				>> tsc_pkg::IFB);
		end
	end

	assign out_v    = v_sx;
	assign out_side = side_sx;

endmodule

[rtl/tsc_horner.sv]
// Horner chain: five stages per series term, multiply then divide by the term constant.
module tsc_horner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  tsc_pkg::tsc_side_t in_side,
	output logic               out_v,
	output tsc_pkg::tsc_side_t out_side,
	output tsc_pkg::tsc_acc_t  out_acc
);

	localparam int NS = tsc_pkg::NSTEP;
	localparam int NW = tsc_pkg::N_W;
	localparam int AW = tsc_pkg::ACC_W;
	localparam int P0W = tsc_pkg::NL_W + tsc_pkg::RL_W;
	localparam int P1W = NW + tsc_pkg::R_W - P0W;
	localparam logic [NW:0]   ONE_U = (NW + 1)'(tsc_pkg::ONE_Q);
	localparam logic [NW:0]   LIM_U = (NW + 1)'(tsc_pkg::ACC_LIM);
	localparam logic [AW-1:0] LIM_A = AW'(tsc_pkg::ACC_LIM);

	logic               hv   [0:NS];
	tsc_pkg::tsc_side_t hside[0:NS];
	tsc_pkg::tsc_acc_t  hacc [0:NS];

	assign hv[0]       = in_v;
	assign hside[0]    = in_side;
	assign hacc[0].neg = 1'b0;
	assign hacc[0].mag = AW'(tsc_pkg::ONE_Q);

	for (genvar j = 0; j < NS; j++) begin : g_step
		localparam int K = tsc_pkg::NSTEP - j;
		localparam logic [63:0] DSV = 64'(tsc_pkg::D_SIN[K]);
		localparam logic [63:0] DCV = 64'(tsc_pkg::D_COS[K]);
		localparam logic [63:0] RSV = ((64'd1 << tsc_pkg::RSH) + DSV - 64'd1) / DSV;
		localparam logic [63:0] RCV = ((64'd1 << tsc_pkg::RSH) + DCV - 64'd1) / DCV;

		logic               v_s1, v_s2, v_s3, v_s4, v_s5;
		logic               neg_s1, neg_s2, neg_s3, neg_s4;
		tsc_pkg::tsc_side_t side_s1, side_s2, side_s3, side_s4, side_s5;
		tsc_pkg::tsc_acc_t  acc_s5;

		logic [tsc_pkg::PL_W-1:0]               pl_s1;
		logic [tsc_pkg::PH_W-1:0]               ph_s1;
		logic [NW-1:0]                          n_s2;
		logic [P0W-1:0]                         pp0_s3, pp2_s3;
		logic [P1W-1:0]                         pp1_s3, pp3_s3;
		logic [NW-1:0]                          q_s4;

		logic [tsc_pkg::D_W-1:0] d_sel;
		logic [tsc_pkg::R_W-1:0] r_sel;
		logic [63:0]             sum_b;
		logic [95:0]             sum_d;
		logic [NW-1:0]           nl, nh;
		logic [tsc_pkg::R_W-1:0] rl, rh;
		logic [NW:0]             up, dn;
		tsc_pkg::tsc_acc_t       acc_e;

		// rounding term d * 2^(IFB-1), then floor by 2^IFB
		assign d_sel = side_s1.func ? DCV[tsc_pkg::D_W-1:0] : DSV[tsc_pkg::D_W-1:0];
		assign sum_b = 64'(pl_s1) + (64'(ph_s1) << tsc_pkg::ACC_LO)
			+ (64'(d_sel) << (tsc_pkg::IFB - 1));

		// exact floor(n / d) by reciprocal
		assign r_sel = side_s2.func ? RCV[tsc_pkg::R_W-1:0] : RSV[tsc_pkg::R_W-1:0];
		assign nl    = NW'(n_s2[tsc_pkg::NL_W-1:0]);
		assign nh    = n_s2 >> tsc_pkg::NL_W;
		assign rl    = tsc_pkg::R_W'(r_sel[tsc_pkg::RL_W-1:0]);
		assign rh    = r_sel >> tsc_pkg::RL_W;
		assign sum_d = 96'(pp0_s3) + (96'(pp1_s3) << tsc_pkg::RL_W)
			+ (96'(pp2_s3) << tsc_pkg::NL_W)
			+ (96'(pp3_s3) << (tsc_pkg::NL_W + tsc_pkg::RL_W));

		// acc = clamp(1 - sign * q)
		assign up = ONE_U + (NW + 1)'(q_s4);
		assign dn = (NW + 1)'(q_s4) - ONE_U;

		always_comb begin
			if (neg_s4) begin
				acc_e.neg = 1'b0;
				acc_e.mag = (up > LIM_U) ? LIM_A : AW'(up);
			end else if ((NW + 1)'(q_s4) <= ONE_U) begin
				acc_e.neg = 1'b0;
				acc_e.mag = AW'(ONE_U - (NW + 1)'(q_s4));
			end else begin
				acc_e.neg = 1'b1;
				acc_e.mag = (dn > LIM_U) ? LIM_A : AW'(dn);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1 <= 1'b0;
				v_s2 <= 1'b0;
				v_s3 <= 1'b0;
				v_s4 <= 1'b0;
				v_s5 <= 1'b0;
			end else if (en) begin
				v_s1 <= hv[j];
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s1 <= hside[j];
				neg_s1  <= hacc[j].neg;
				pl_s1   <= tsc_pkg::PL_W'(hside[j].x2)
					* tsc_pkg::PL_W'(hacc[j].mag[tsc_pkg::ACC_LO-1:0]);
				ph_s1   <= tsc_pkg::PH_W'(hside[j].x2)
					* tsc_pkg::PH_W'(hacc[j].mag[AW-1:tsc_pkg::ACC_LO]);
				side_s2 <= side_s1;
				neg_s2  <= neg_s1;
				n_s2    <= sum_b[tsc_pkg::IFB +: NW];
				side_s3 <= side_s2;
				neg_s3  <= neg_s2;
				pp0_s3  <= P0W'(nl) * P0W'(rl);
				pp1_s3  <= P1W'(nl) * P1W'(rh);
				pp2_s3  <= P0W'(nh) * P0W'(rl);
				pp3_s3  <= P1W'(nh) * P1W'(rh);
				side_s4 <= side_s3;
				neg_s4  <= neg_s3;
				q_s4    <= sum_d[tsc_pkg::RSH +: NW];
				side_s5 <= side_s4;
				acc_s5  <= acc_e;
			end
		end

		assign hv[j+1]    = v_s5;
		assign hside[j+1] = side_s5;
		assign hacc[j+1]  = acc_s5;
	end

	assign out_v    = hv[NS];
	assign out_side = hside[NS];
	assign out_acc  = hacc[NS];

endmodule

[rtl/tsc_out.sv]
// Final sine multiply, rounding to the output format and saturation.
module tsc_out (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_v,
	input  tsc_pkg::tsc_side_t        side,
	input  tsc_pkg::tsc_acc_t         acc,
	output logic                      out_v,
	output logic [tsc_pkg::VAL_W-1:0] value
);

	localparam int PW = tsc_pkg::XM_W + tsc_pkg::ACC_W - tsc_pkg::ACC_LO;
	localparam int SW = tsc_pkg::RM_W + 1;
	localparam int VW = tsc_pkg::VAL_W;

	logic                        v_s1, v_s2, v_s3;
	logic                        cos_s1, neg_s1, neg_s2;
	logic [tsc_pkg::ACC_W-1:0]   mag_s1;
	logic [PW-1:0]               pl_s1, ph_s1;
	logic [tsc_pkg::RM_W-1:0]    rmag_s2;
	logic [VW-1:0]               value_s3;

	logic [63:0]   prod;
	logic [SW-1:0] rs;
	logic [VW-1:0] sat;

	assign prod = 64'(pl_s1) + (64'(ph_s1) << tsc_pkg::ACC_LO) + (tsc_pkg::ONE_Q >> 1);
	assign rs   = (SW'(rmag_s2) + SW'(tsc_pkg::RND)) >> tsc_pkg::SH;

	always_comb begin
		if (neg_s2) begin
			sat = (rs > SW'(tsc_pkg::OUT_MIN_MAG)) ? VW'(-tsc_pkg::OUT_MIN_MAG)
				: VW'(0) - VW'(rs);
		end else begin
			sat = (rs > SW'(tsc_pkg::OUT_MAX)) ? VW'(tsc_pkg::OUT_MAX) : VW'(rs);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_s1   <= side.func;
			neg_s1   <= side.func ? acc.neg : (side.xneg ^ acc.neg);
			mag_s1   <= acc.mag;
			pl_s1    <= PW'(side.xm) * PW'(acc.mag[tsc_pkg::ACC_LO-1:0]);
			ph_s1    <= PW'(side.xm) * PW'(acc.mag[tsc_pkg::ACC_W-1:tsc_pkg::ACC_LO]);
			neg_s2   <= neg_s1;
			rmag_s2  <= cos_s1 ? tsc_pkg::RM_W'(mag_s1)
				: tsc_pkg::RM_W'(prod >> tsc_pkg::IFB);
			value_s3 <= sat;
		end
	end

	assign out_v = v_s3;
	assign value = value_s3;

endmodule

[rtl/sine_cosine_taylor_series.sv]
// Top level of the sine/cosine series pipeline with its result buffer.
//
// One angle (signed Q7.16 radians) and selector beat is taken every cycle while ready
// is high; the result is signed Q2.16, saturated. The Horner chain has five register
// stages per term (split multiply, round, reciprocal multiply, sum, update), and follows
// a five-stage remainder by the period 6.283 and squaring.
// A two-entry result buffer keeps ready high while a result waits; ready drops only
// when both entries are full, and every stage then holds.
module sine_cosine_taylor_series (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid,
	output logic                             ready,
	input  logic signed [tsc_pkg::ANG_W-1:0] angle,
	input  logic                             func,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic signed [tsc_pkg::VAL_W-1:0] value
);

	logic                      en;
	logic                      red_v, hor_v, last_v;
	tsc_pkg::tsc_side_t        red_side, hor_side;
	tsc_pkg::tsc_acc_t         hor_acc;
	logic [tsc_pkg::VAL_W-1:0] last_value;

	logic                      out_v_q, skid_v_q;
	logic [tsc_pkg::VAL_W-1:0] out_q, skid_q;
	logic                      pop, push;

	assign en    = !skid_v_q;
	assign ready = en;

	tsc_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (valid),
		.angle    (angle),
		.func     (func),
		.out_v    (red_v),
		.out_side (red_side)
	);

	tsc_horner u_horner (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (red_v),
		.in_side  (red_side),
		.out_v    (hor_v),
		.out_side (hor_side),
		.out_acc  (hor_acc)
	);

	tsc_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (hor_v),
		.side   (hor_side),
		.acc    (hor_acc),
		.out_v  (last_v),
		.value  (last_value)
	);

	assign pop  = out_v_q & res_ready;
	assign push = en & last_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (out_v_q && !pop) begin
			if (push) begin
				skid_v_q <= 1'b1;
			end
		end else begin
			out_v_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (out_v_q && !pop) begin
			if (push) begin
				skid_q <= last_value;
			end
		end else if (push) begin
			out_q <= last_value;
		end
	end

	assign res_valid = out_v_q;
	assign value     = $signed(out_q);

endmodule
